### rtl/bsd_pkg.sv
// ----------------------------------------------------------------------------
// bsd_pkg
// shared types, codes and constants of the bitmap stream decoder
// ----------------------------------------------------------------------------
package bsd_pkg;

    // default image size limits
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // file position counter, saturating, wide enough for any 32-bit offset
    localparam int POS_W = 34;
    // stored image dimensions, saturated well above any size limit
    localparam int DIM_W = 14;

    // result queue
    localparam int QUEUE_DEPTH = 8;
    localparam int MAX_PER_ITEM = 3;

    // parse phases
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_GAP_PAL,
        PH_PALETTE,
        PH_GAP_MASK,
        PH_MASKS,
        PH_GAP_DATA,
        PH_DATA,
        PH_DONE
    } phase_t;

    // result kinds
    localparam logic [1:0] KIND_PIXEL   = 2'd0;
    localparam logic [1:0] KIND_PALETTE = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SIGNATURE = 3'd1;
    localparam logic [2:0] ST_SMALL_HDR = 3'd2;
    localparam logic [2:0] ST_COMPRESS  = 3'd3;
    localparam logic [2:0] ST_DEPTH     = 3'd4;
    localparam logic [2:0] ST_TOO_LARGE = 3'd5;
    localparam logic [2:0] ST_OFFSET    = 3'd6;
    localparam logic [2:0] ST_TRUNCATED = 3'd7;

    // header byte positions (last byte of each field)
    localparam logic [POS_W-1:0] POS_SIG    = POS_W'(1);
    localparam logic [POS_W-1:0] POS_OFFSET = POS_W'(13);
    localparam logic [POS_W-1:0] POS_HSIZE  = POS_W'(17);
    localparam logic [POS_W-1:0] POS_WIDTH  = POS_W'(21);
    localparam logic [POS_W-1:0] POS_HEIGHT = POS_W'(25);
    localparam logic [POS_W-1:0] POS_DEPTH  = POS_W'(29);
    localparam logic [POS_W-1:0] POS_COMP   = POS_W'(33);
    localparam logic [POS_W-1:0] POS_CHECK  = POS_W'(37);
    localparam logic [POS_W-1:0] POS_AFTER_HDR  = POS_W'(38);
    localparam logic [POS_W-1:0] FILE_HDR_BYTES = POS_W'(14);
    localparam logic [POS_W-1:0] MASK_GAP_BYTES = POS_W'(16);
    localparam logic [15:0]      MASK_BYTES     = 16'd16;

    localparam logic [7:0]  SIG_B = 8'h42;
    localparam logic [7:0]  SIG_M = 8'h4D;
    localparam logic [31:0] HDR_SIZE_MIN   = 32'd24;
    localparam logic [31:0] HDR_SIZE_V3    = 32'd56;
    localparam logic [31:0] HDR_SIZE_V5    = 32'd124;
    localparam logic [31:0] COMP_NONE      = 32'd0;
    localparam logic [31:0] COMP_BITFIELDS = 32'd3;

    localparam logic [5:0] BPP_4  = 6'd4;
    localparam logic [5:0] BPP_8  = 6'd8;
    localparam logic [5:0] BPP_24 = 6'd24;
    localparam logic [5:0] BPP_32 = 6'd32;
    localparam logic [5:0] BPP_SAT = 6'd63;

    localparam logic [8:0] PAL_ENTRIES_8 = 9'd256;
    localparam logic [8:0] PAL_ENTRIES_4 = 9'd16;

    // one result item
    typedef struct packed {
        logic [1:0]  item_kind;
        logic [11:0] column;
        logic [11:0] row;
        logic [31:0] colour_value;
        logic        is_indexed;
        logic        alpha_valid;
        logic [2:0]  status_code;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic        last_of_run;
    } result_t;

    // results caused by one input item
    typedef struct packed {
        logic [1:0]                    count;
        result_t [MAX_PER_ITEM-1:0]    item;
    } push_t;

    // channel shift for the common byte-aligned masks
    function automatic logic [4:0] norm_shift(input logic [31:0] m);
        logic [4:0] s;
        s = 5'd0;
        if (m == 32'hFF00_0000)
            s = 5'd24;
        else if (m == 32'h00FF_0000)
            s = 5'd16;
        else if (m == 32'h0000_FF00)
            s = 5'd8;
        return s;
    endfunction

endpackage

### rtl/bsd_parser.sv
// ----------------------------------------------------------------------------
// bsd_parser
// per-byte header, palette, mask and pixel decode
// ----------------------------------------------------------------------------
module bsd_parser #(
    parameter int MAX_WIDTH  = bsd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bsd_pkg::MAX_HEIGHT_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           take,
    input  logic [7:0]     in_byte,
    input  logic           end_of_file,
    output bsd_pkg::push_t push
);

    localparam int PW = bsd_pkg::POS_W;
    localparam int DW = bsd_pkg::DIM_W;

    bsd_pkg::phase_t phase_reg, phase_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] sect_reg, sect_next;
    logic [31:0]   fs_reg, fs_next;
    logic [31:0]   offset_reg, offset_next;
    logic [31:0]   hsize_reg, hsize_next;
    logic [DW-1:0] width_reg, width_next;
    logic [DW-1:0] height_reg, height_next;
    logic [5:0]    bpp_reg, bpp_next;
    logic          bitf_reg, bitf_next;
    logic          ext_reg, ext_next;
    logic [31:0]   mask_reg [4];
    logic [31:0]   mask_next [4];
    logic [4:0]    shift_reg [4];
    logic [4:0]    shift_next [4];
    logic [8:0]    pal_rem_reg, pal_rem_next;
    logic          pal_big_reg, pal_big_next;
    logic [31:0]   acc_reg, acc_next;
    logic [1:0]    bip_reg, bip_next;
    logic [DW-1:0] col_reg, col_next;
    logic [DW-1:0] rowc_reg, rowc_next;
    logic [15:0]   rbc_reg, rbc_next;
    logic [15:0]   padded_reg, padded_next;

    // per-byte scratch
    logic [PW-1:0] pos_inc, nxt;
    logic [31:0]   fs_shift, acc_v, pix;
    logic [31:0]   ch_a, ch_b, ch_g, ch_r;
    logic [2:0]    bip_sum;
    logic [15:0]   rdb, rbc_v;
    logic [8:0]    pal_idx;
    logic [1:0]    mk;
    logic          req_after, req_data, fin0, start_pal;

    // result slots: first pixel or palette entry, second pixel, status
    logic          e0v, e1v, stv;
    logic [1:0]    e0_kind;
    logic [11:0]   e0_col, e0_row, e1_col;
    logic [31:0]   e0_val, e1_val;
    logic          e0_idx;
    logic [2:0]    st_code;
    // item dimensions as seen by the results of this byte
    logic [DW-1:0] out_w, out_h;
    logic          out_ext;

    always_comb
    begin
        unique case (bpp_reg)
            bsd_pkg::BPP_32: rdb = {width_reg, 2'b00};
            bsd_pkg::BPP_24: rdb = {1'b0, width_reg, 1'b0} + {2'b00, width_reg};
            bsd_pkg::BPP_8:  rdb = {2'b00, width_reg};
            default:         rdb = 16'(({2'b00, width_reg} + 16'd1) >> 1);
        endcase
    end

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        sect_next    = sect_reg;
        fs_next      = fs_reg;
        offset_next  = offset_reg;
        hsize_next   = hsize_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        bpp_next     = bpp_reg;
        bitf_next    = bitf_reg;
        ext_next     = ext_reg;
        mask_next    = mask_reg;
        shift_next   = shift_reg;
        pal_rem_next = pal_rem_reg;
        pal_big_next = pal_big_reg;
        acc_next     = acc_reg;
        bip_next     = bip_reg;
        col_next     = col_reg;
        rowc_next    = rowc_reg;
        rbc_next     = rbc_reg;
        padded_next  = padded_reg;

        e0v = 1'b0;
        e1v = 1'b0;
        stv = 1'b0;
        e0_kind = bsd_pkg::KIND_PIXEL;
        e0_col = '0;
        e0_row = '0;
        e1_col = '0;
        e0_val = '0;
        e1_val = '0;
        e0_idx = 1'b0;
        st_code = bsd_pkg::ST_OK;
        req_after = 1'b0;
        req_data = 1'b0;
        fin0 = 1'b0;
        start_pal = 1'b0;
        pix = '0;
        ch_a = '0;
        ch_b = '0;
        ch_g = '0;
        ch_r = '0;
        pal_idx = '0;
        mk = '0;
        rbc_v = rbc_reg + 16'd1;

        pos_inc = (pos_reg == '1) ? pos_reg : pos_reg + PW'(1);
        nxt = pos_inc;
        fs_shift = {in_byte, fs_reg[31:8]};
        acc_v = acc_reg | ({24'b0, in_byte} << {bip_reg, 3'b000});
        bip_sum = {1'b0, bip_reg} + 3'd1;

        unique case (phase_reg)
            bsd_pkg::PH_HEADER:
            begin
                fs_next = fs_shift;
                case (pos_reg)
                    bsd_pkg::POS_SIG:
                    begin
                        if (fs_shift[23:16] != bsd_pkg::SIG_B
                            || fs_shift[31:24] != bsd_pkg::SIG_M)
                        begin
                            stv = 1'b1;
                            st_code = bsd_pkg::ST_SIGNATURE;
                        end
                    end
                    bsd_pkg::POS_OFFSET: offset_next = fs_shift;
                    bsd_pkg::POS_HSIZE:
                    begin
                        hsize_next = fs_shift;
                        ext_next = (fs_shift == bsd_pkg::HDR_SIZE_V3)
                                   || (fs_shift == bsd_pkg::HDR_SIZE_V5);
                        if (fs_shift < bsd_pkg::HDR_SIZE_MIN)
                        begin
                            stv = 1'b1;
                            st_code = bsd_pkg::ST_SMALL_HDR;
                        end
                    end
                    bsd_pkg::POS_WIDTH:
                        width_next = (fs_shift > 32'({DW{1'b1}})) ? '1 : fs_shift[DW-1:0];
                    bsd_pkg::POS_HEIGHT:
                        height_next = (fs_shift > 32'({DW{1'b1}})) ? '1 : fs_shift[DW-1:0];
                    bsd_pkg::POS_DEPTH:
                        bpp_next = (fs_shift[31:16] > 16'(bsd_pkg::BPP_SAT))
                                   ? bsd_pkg::BPP_SAT : fs_shift[21:16];
                    bsd_pkg::POS_COMP:
                    begin
                        if (fs_shift != bsd_pkg::COMP_NONE
                            && !(fs_shift == bsd_pkg::COMP_BITFIELDS && ext_reg))
                        begin
                            stv = 1'b1;
                            st_code = bsd_pkg::ST_COMPRESS;
                        end
                        else
                        begin
                            bitf_next = (fs_shift == bsd_pkg::COMP_BITFIELDS);
                        end
                    end
                    bsd_pkg::POS_CHECK:
                    begin
                        if (bpp_reg != bsd_pkg::BPP_4 && bpp_reg != bsd_pkg::BPP_8
                            && bpp_reg != bsd_pkg::BPP_24 && bpp_reg != bsd_pkg::BPP_32)
                        begin
                            stv = 1'b1;
                            st_code = bsd_pkg::ST_DEPTH;
                        end
                        else if (32'(width_reg) > 32'(MAX_WIDTH)
                                 || 32'(height_reg) > 32'(MAX_HEIGHT))
                        begin
                            stv = 1'b1;
                            st_code = bsd_pkg::ST_TOO_LARGE;
                        end
                        else if (bpp_reg <= bsd_pkg::BPP_8)
                        begin
                            sect_next = bsd_pkg::FILE_HDR_BYTES + PW'(hsize_reg);
                            if (sect_next == bsd_pkg::POS_AFTER_HDR)
                                start_pal = 1'b1;
                            else
                                phase_next = bsd_pkg::PH_GAP_PAL;
                        end
                        else
                        begin
                            req_after = 1'b1;
                            nxt = bsd_pkg::POS_AFTER_HDR;
                        end
                    end
                    default: ;
                endcase
            end
            bsd_pkg::PH_GAP_PAL:
            begin
                if (pos_inc == sect_reg)
                    start_pal = 1'b1;
            end
            bsd_pkg::PH_PALETTE:
            begin
                if (bip_sum == 3'd4)
                begin
                    pal_idx = (pal_big_reg ? bsd_pkg::PAL_ENTRIES_8 : bsd_pkg::PAL_ENTRIES_4)
                              - pal_rem_reg;
                    e0v = 1'b1;
                    e0_kind = bsd_pkg::KIND_PALETTE;
                    e0_col = {4'b0, pal_idx[7:0]};
                    // alpha of zero reads as opaque
                    e0_val = {(acc_v[31:24] != 8'd0) ? acc_v[31:24] : 8'hFF,
                              acc_v[7:0], acc_v[15:8], acc_v[23:16]};
                    acc_next = '0;
                    bip_next = '0;
                    pal_rem_next = pal_rem_reg - 9'd1;
                    if (pal_rem_next == 9'd0)
                        req_after = 1'b1;
                end
                else
                begin
                    acc_next = acc_v;
                    bip_next = bip_sum[1:0];
                end
            end
            bsd_pkg::PH_GAP_MASK:
            begin
                if (pos_inc == sect_reg)
                begin
                    phase_next = bsd_pkg::PH_MASKS;
                    rbc_next = '0;
                end
            end
            bsd_pkg::PH_MASKS:
            begin
                fs_next = fs_shift;
                rbc_next = rbc_v;
                if (rbc_v[1:0] == 2'b00)
                begin
                    mk = rbc_v[3:2] - 2'd1;
                    mask_next[mk] = fs_shift;
                    shift_next[mk] = bsd_pkg::norm_shift(fs_shift);
                end
                if (rbc_v >= bsd_pkg::MASK_BYTES)
                begin
                    rbc_next = '0;
                    req_data = 1'b1;
                end
            end
            bsd_pkg::PH_GAP_DATA:
            begin
                if (pos_inc == PW'(offset_reg))
                    phase_next = bsd_pkg::PH_DATA;
            end
            bsd_pkg::PH_DATA:
            begin
                if (rbc_reg < rdb)
                begin
                    e0_col = col_reg[11:0];
                    e0_row = 12'(height_reg - DW'(1) - rowc_reg);
                    fin0 = (col_reg + DW'(1) >= width_reg)
                           && (rowc_reg + DW'(1) >= height_reg);
                    unique case (bpp_reg)
                        bsd_pkg::BPP_32, bsd_pkg::BPP_24:
                        begin
                            if (bip_sum == ((bpp_reg == bsd_pkg::BPP_32) ? 3'd4 : 3'd3))
                            begin
                                if (bpp_reg == bsd_pkg::BPP_24)
                                begin
                                    pix = {8'hFF, acc_v[7:0], acc_v[15:8], acc_v[23:16]};
                                end
                                else
                                begin
                                    ch_a = ext_reg ? ((acc_v & mask_reg[3]) >> shift_reg[3])
                                                   : 32'hFF;
                                    ch_b = (acc_v & mask_reg[2]) >> shift_reg[2];
                                    ch_g = (acc_v & mask_reg[1]) >> shift_reg[1];
                                    ch_r = (acc_v & mask_reg[0]) >> shift_reg[0];
                                    pix = (ch_a << 24) | (ch_b << 16) | (ch_g << 8) | ch_r;
                                end
                                acc_next = '0;
                                bip_next = '0;
                                e0v = 1'b1;
                                e0_val = pix;
                                col_next = col_reg + DW'(1);
                                if (fin0)
                                begin
                                    stv = 1'b1;
                                    st_code = bsd_pkg::ST_OK;
                                end
                            end
                            else
                            begin
                                acc_next = acc_v;
                                bip_next = bip_sum[1:0];
                            end
                        end
                        bsd_pkg::BPP_8:
                        begin
                            e0v = 1'b1;
                            e0_idx = 1'b1;
                            e0_val = {24'b0, in_byte};
                            col_next = col_reg + DW'(1);
                            if (fin0)
                                stv = 1'b1;
                        end
                        default:
                        begin
                            // two pixels per byte, high nibble first
                            e0v = 1'b1;
                            e0_idx = 1'b1;
                            e0_val = {28'b0, in_byte[7:4]};
                            col_next = col_reg + DW'(1);
                            if (fin0)
                            begin
                                stv = 1'b1;
                            end
                            else if (col_reg + DW'(1) < width_reg)
                            begin
                                e1v = 1'b1;
                                e1_col = 12'(col_reg + DW'(1));
                                e1_val = {28'b0, in_byte[3:0]};
                                col_next = col_reg + DW'(2);
                                if ((col_reg + DW'(2) >= width_reg)
                                    && (rowc_reg + DW'(1) >= height_reg))
                                    stv = 1'b1;
                            end
                        end
                    endcase
                end
                if (!stv)
                begin
                    rbc_next = rbc_v;
                    if (rbc_v >= padded_reg)
                    begin
                        rbc_next = '0;
                        col_next = '0;
                        bip_next = '0;
                        acc_next = '0;
                        rowc_next = rowc_reg + DW'(1);
                    end
                end
            end
            default: ;
        endcase

        if (start_pal)
        begin
            pal_big_next = (bpp_reg == bsd_pkg::BPP_8);
            pal_rem_next = (bpp_reg == bsd_pkg::BPP_8) ? bsd_pkg::PAL_ENTRIES_8
                                                       : bsd_pkg::PAL_ENTRIES_4;
            bip_next = '0;
            acc_next = '0;
            phase_next = bsd_pkg::PH_PALETTE;
        end

        if (req_after)
        begin
            if (bitf_reg)
            begin
                sect_next = nxt + bsd_pkg::MASK_GAP_BYTES;
                phase_next = bsd_pkg::PH_GAP_MASK;
            end
            else
            begin
                req_data = 1'b1;
            end
        end

        if (req_data)
        begin
            if (PW'(offset_reg) < nxt)
            begin
                stv = 1'b1;
                st_code = bsd_pkg::ST_OFFSET;
            end
            else if (width_reg == '0 || height_reg == '0)
            begin
                stv = 1'b1;
                st_code = bsd_pkg::ST_OK;
            end
            else
            begin
                padded_next = (rdb + 16'd3) & ~16'd3;
                rbc_next = '0;
                col_next = '0;
                rowc_next = '0;
                bip_next = '0;
                acc_next = '0;
                phase_next = (PW'(offset_reg) == nxt) ? bsd_pkg::PH_DATA
                                                      : bsd_pkg::PH_GAP_DATA;
            end
        end

        if (stv)
            phase_next = bsd_pkg::PH_DONE;

        // early end of file
        if (end_of_file && phase_next != bsd_pkg::PH_DONE)
        begin
            stv = 1'b1;
            st_code = bsd_pkg::ST_TRUNCATED;
        end

        out_w = width_next;
        out_h = height_next;
        out_ext = ext_next;
    end

    // result packing
    always_comb
    begin
        bsd_pkg::result_t e0, e1, st;
        logic [1:0] cnt;
        e0 = '0;
        e0.item_kind = e0_kind;
        e0.column = e0_col;
        e0.row = (e0_kind == bsd_pkg::KIND_PIXEL) ? e0_row : 12'd0;
        e0.colour_value = e0_val;
        e0.is_indexed = e0_idx;
        e0.alpha_valid = out_ext;
        e0.image_width = (out_w > DW'(13'h1FFF)) ? 13'h1FFF : out_w[12:0];
        e0.image_height = (out_h > DW'(13'h1FFF)) ? 13'h1FFF : out_h[12:0];
        e1 = e0;
        e1.item_kind = bsd_pkg::KIND_PIXEL;
        e1.column = e1_col;
        e1.colour_value = e1_val;
        e1.is_indexed = 1'b1;
        st = e0;
        st.item_kind = bsd_pkg::KIND_STATUS;
        st.column = '0;
        st.row = '0;
        st.colour_value = '0;
        st.is_indexed = 1'b0;
        st.status_code = st_code;

        push.item = '0;
        cnt = 2'd0;
        if (e0v)
        begin
            push.item[0] = e0;
            cnt = 2'd1;
        end
        if (e1v)
        begin
            push.item[1] = e1;
            cnt = 2'd2;
        end
        if (stv)
        begin
            push.item[cnt] = st;
            cnt = cnt + 2'd1;
        end
        if (cnt != 2'd0)
            push.item[cnt - 2'd1].last_of_run = 1'b1;
        push.count = cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= bsd_pkg::PH_HEADER;
            pos_reg     <= '0;
            sect_reg    <= '0;
            fs_reg      <= '0;
            offset_reg  <= '0;
            hsize_reg   <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            bpp_reg     <= '0;
            bitf_reg    <= 1'b0;
            ext_reg     <= 1'b0;
            mask_reg[0] <= 32'h0000_00FF;
            mask_reg[1] <= 32'h0000_FF00;
            mask_reg[2] <= 32'h00FF_0000;
            mask_reg[3] <= 32'hFF00_0000;
            shift_reg[0] <= 5'd0;
            shift_reg[1] <= 5'd8;
            shift_reg[2] <= 5'd16;
            shift_reg[3] <= 5'd24;
            pal_rem_reg <= '0;
            pal_big_reg <= 1'b0;
            acc_reg     <= '0;
            bip_reg     <= '0;
            col_reg     <= '0;
            rowc_reg    <= '0;
            rbc_reg     <= '0;
            padded_reg  <= '0;
        end
        else if (take && end_of_file)
        begin
            // end of file returns the parser to its start state
            phase_reg   <= bsd_pkg::PH_HEADER;
            pos_reg     <= '0;
            sect_reg    <= '0;
            fs_reg      <= '0;
            offset_reg  <= '0;
            hsize_reg   <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            bpp_reg     <= '0;
            bitf_reg    <= 1'b0;
            ext_reg     <= 1'b0;
            mask_reg[0] <= 32'h0000_00FF;
            mask_reg[1] <= 32'h0000_FF00;
            mask_reg[2] <= 32'h00FF_0000;
            mask_reg[3] <= 32'hFF00_0000;
            shift_reg[0] <= 5'd0;
            shift_reg[1] <= 5'd8;
            shift_reg[2] <= 5'd16;
            shift_reg[3] <= 5'd24;
            pal_rem_reg <= '0;
            pal_big_reg <= 1'b0;
            acc_reg     <= '0;
            bip_reg     <= '0;
            col_reg     <= '0;
            rowc_reg    <= '0;
            rbc_reg     <= '0;
            padded_reg  <= '0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_inc;
            sect_reg    <= sect_next;
            fs_reg      <= fs_next;
            offset_reg  <= offset_next;
            hsize_reg   <= hsize_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            bpp_reg     <= bpp_next;
            bitf_reg    <= bitf_next;
            ext_reg     <= ext_next;
            mask_reg    <= mask_next;
            shift_reg   <= shift_next;
            pal_rem_reg <= pal_rem_next;
            pal_big_reg <= pal_big_next;
            acc_reg     <= acc_next;
            bip_reg     <= bip_next;
            col_reg     <= col_next;
            rowc_reg    <= rowc_next;
            rbc_reg     <= rbc_next;
            padded_reg  <= padded_next;
        end
    end

endmodule

### rtl/bsd_queue.sv
// ----------------------------------------------------------------------------
// bsd_queue
// result queue, up to three writes and one read per cycle
// ----------------------------------------------------------------------------
module bsd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  bsd_pkg::push_t   push,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output bsd_pkg::result_t head
);

    localparam int DEPTH = bsd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bsd_pkg::result_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       n_in;
    logic             pop;

    assign n_in = take ? push.count : 2'd0;
    assign pop = out_valid && !out_stall;
    assign out_valid = (cnt_reg != '0);
    assign head = slot_reg[rd_reg];
    // room must remain for the largest burst of one item
    assign full = (cnt_reg > CNT_W'(DEPTH - bsd_pkg::MAX_PER_ITEM));

    always_comb
    begin
        wr_next = wr_reg + PTR_W'(n_in);
        rd_next = pop ? rd_reg + PTR_W'(1) : rd_reg;
        cnt_next = cnt_reg + CNT_W'(n_in) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < bsd_pkg::MAX_PER_ITEM; i++)
        begin
            if (2'(i) < n_in)
                slot_reg[wr_reg + PTR_W'(i)] <= push.item[i];
        end
    end

endmodule

### rtl/bmp_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// bmp_stream_decoder_core
// streaming bitmap file decoder: headers, palette, masks and pixels
// ----------------------------------------------------------------------------
//
// channel   dir   handshake              payload
// input     in    in_valid / in_stall    in_byte, end_of_file
// output    out   out_valid / out_stall  item_kind .. last_of_run
//
// one file byte is taken per cycle while in_stall is low; each byte
// yields zero to three items; items wait in an eight-entry queue, so the
// output side drains one a cycle while out_stall is low, and 4-bit images
// are held back once the queue fills; in_stall rises while fewer than three
// queue entries are free; rst_n clears the parser and the queue at once;
// end_of_file does the same for the parser after its byte
//
module bmp_stream_decoder_core #(
    parameter int MAX_WIDTH  = bsd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bsd_pkg::MAX_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  item_kind,
    output logic [11:0] column,
    output logic [11:0] row,
    output logic [31:0] colour_value,
    output logic        is_indexed,
    output logic        alpha_valid,
    output logic [2:0]  status_code,
    output logic [12:0] image_width,
    output logic [12:0] image_height,
    output logic        last_of_run
);

    logic             take;
    logic             full;
    bsd_pkg::push_t   push;
    bsd_pkg::result_t head;

    // a byte is taken whenever the queue has room for its worst case
    assign in_stall = full;
    assign take = in_valid && !full;

    // byte decode and parser state
    bsd_parser #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .in_byte     (in_byte),
        .end_of_file (end_of_file),
        .push        (push)
    );

    // result queue toward the output channel
    bsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .push      (push),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign item_kind    = head.item_kind;
    assign column       = head.column;
    assign row          = head.row;
    assign colour_value = head.colour_value;
    assign is_indexed   = head.is_indexed;
    assign alpha_valid  = head.alpha_valid;
    assign status_code  = head.status_code;
    assign image_width  = head.image_width;
    assign image_height = head.image_height;
    assign last_of_run  = head.last_of_run;

    // a stalled output item holds steady
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(head))
        else $error("output item changed while stalled");

    // a status item always closes the run of its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind == bsd_pkg::KIND_STATUS |-> last_of_run)
        else $error("status item not last of its run");

    // input stalls only while the queue holds items
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty queue");

endmodule
